// ===== rtl/cmie_pkg.sv =====
// shared types, constants and helpers of the card machine instruction executor
package cmie_pkg;

  localparam int unsigned MEM_WORDS_DEF  = 100;
  localparam int unsigned CARD_WORDS_DEF = 10;

  localparam logic [31:0] SPACES = 32'h2020_2020;
  localparam logic [7:0]  CH_G   = "G";
  localparam logic [7:0]  CH_D   = "D";
  localparam logic [7:0]  CH_P   = "P";
  localparam logic [7:0]  CH_H   = "H";
  localparam logic [7:0]  CH_L   = "L";
  localparam logic [7:0]  CH_S   = "S";
  localparam logic [7:0]  CH_C   = "C";
  localparam logic [7:0]  CH_R   = "R";
  localparam logic [7:0]  CH_B   = "B";
  localparam logic [7:0]  CH_T   = "T";
  localparam logic [7:0]  CH_0   = "0";
  localparam logic [7:0]  CH_9   = "9";

  typedef enum logic [2:0] {
    FUNC_CLEAR  = 3'd0,
    FUNC_LOAD   = 3'd1,
    FUNC_EXEC   = 3'd2,
    FUNC_DATA   = 3'd3,
    FUNC_NODATA = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_AWAIT   = 3'd1,
    ST_HALTED  = 3'd2,
    ST_NODATA  = 3'd3,
    ST_PRINT   = 3'd4,
    ST_FAULT   = 3'd5,
    ST_IGNORED = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    OP_GD, OP_PD, OP_H, OP_LR, OP_SR, OP_CR, OP_BT, OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    RD_WADDR, RD_IC, RD_OPADDR, RD_FILL, RD_PD
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_LOAD, WR_FILL, WR_STORE
  } wr_sel_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  word_address;
    logic [31:0] word_value;
    logic [2:0]  byte_count;
    logic        card_end;
  } cmie_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_word;
    logic [6:0]  counter_after;
    logic        last;
  } cmie_out_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    clear;
    logic    mem_rd;
    rd_sel_e rd_sel;
    logic    mem_wr;
    wr_sel_e wr_sel;
    logic    ir_load;
    logic    gp_load;
    logic    tog_load;
    logic    ic_adv;
    logic    ic_branch;
    logic    fill_set;
    logic    fill_inc;
    logic    pd_set;
    logic    pd_inc;
    logic    emit;
    status_e emit_status;
    logic    emit_mem;
    logic    emit_last;
  } cmie_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       load_fault;
    logic       card_end;
    logic       fill_room;
    op_e        op;
    logic       op_ok;
    logic       toggle;
    logic       pd_last;
    logic       out_free;
  } cmie_sts_t;

  // overwrite the leading characters of a word
  function automatic logic [31:0] put_bytes(logic [31:0] old, logic [31:0] val,
                                            logic [2:0] cnt);
    logic [31:0] res;
    res = old;
    for (int i = 0; i < 4; i++) begin
      if (cnt > 3'(i)) begin
        res[31-8*i -: 8] = val[31-8*i -: 8];
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/cmie_ram.sv =====
// generic single write port ram with registered read
module cmie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cmie_datapath.sv =====
// datapath: store, registers, decode and output register
module cmie_datapath #(
  parameter int unsigned MEM_WORDS  = cmie_pkg::MEM_WORDS_DEF,
  parameter int unsigned CARD_WORDS = cmie_pkg::CARD_WORDS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmie_pkg::cmie_cmd_t cmd_i,
  output cmie_pkg::cmie_sts_t sts_o,
  input  cmie_pkg::cmie_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cmie_pkg::cmie_out_t out_data_o
);
  import cmie_pkg::*;

  localparam int unsigned IW = $clog2(MEM_WORDS);

  cmie_in_t        item_q;
  logic [31:0]     ir_q, gp_q;
  logic [6:0]      ic_q, fp_q, fl_q, pd_q, pl_q;
  logic            tog_q;
  logic [MEM_WORDS-1:0] valid_q;
  logic            rdv_q;
  logic            out_valid_q;
  cmie_out_t       out_q;

  logic [31:0]     rdata, rd_eff, wdata;
  logic [6:0]      rd_addr, wr_addr, op_addr, ic_inc, lim;
  logic [7:0]      lim_sum;
  logic [7:0]      c0, c1, c2, c3;
  logic            d2_ok, d3_ok;
  op_e             op;

  // read data of a never written word is all spaces
  assign rd_eff = rdv_q ? rdata : SPACES;

  // instruction decode
  assign c0 = ir_q[31:24];
  assign c1 = ir_q[23:16];
  assign c2 = ir_q[15:8];
  assign c3 = ir_q[7:0];
  assign d2_ok = (c2 >= CH_0) && (c2 <= CH_9);
  assign d3_ok = (c3 >= CH_0) && (c3 <= CH_9);
  assign op_addr = 7'((c2 - CH_0) * 8'd10 + (c3 - CH_0));

  always_comb begin
    op = OP_NONE;
    if (c0 == CH_G && c1 == CH_D) begin
      op = OP_GD;
    end else if (c0 == CH_P && c1 == CH_D) begin
      op = OP_PD;
    end else if (c0 == CH_H) begin
      op = OP_H;
    end else if (c0 == CH_L && c1 == CH_R) begin
      op = OP_LR;
    end else if (c0 == CH_S && c1 == CH_R) begin
      op = OP_SR;
    end else if (c0 == CH_C && c1 == CH_R) begin
      op = OP_CR;
    end else if (c0 == CH_B && c1 == CH_T) begin
      op = OP_BT;
    end
  end

  // card window end, clipped to the end of memory
  assign lim_sum = {1'b0, op_addr} + 8'(CARD_WORDS);
  assign lim = (lim_sum > 8'(MEM_WORDS)) ? 7'(MEM_WORDS) : lim_sum[6:0];

  // counter advance with wrap
  assign ic_inc = ({1'b0, ic_q} + 8'd1 >= 8'(MEM_WORDS)) ? 7'd0 : ic_q + 7'd1;

  // memory address and data selection
  always_comb begin
    case (cmd_i.rd_sel)
      RD_WADDR:  rd_addr = item_q.word_address;
      RD_IC:     rd_addr = ic_q;
      RD_OPADDR: rd_addr = op_addr;
      RD_FILL:   rd_addr = fp_q;
      RD_PD:     rd_addr = pd_q;
      default:   rd_addr = ic_q;
    endcase
    case (cmd_i.wr_sel)
      WR_LOAD: begin
        wr_addr = item_q.word_address;
        wdata   = put_bytes(rd_eff, item_q.word_value, item_q.byte_count);
      end
      WR_FILL: begin
        wr_addr = fp_q;
        wdata   = put_bytes(rd_eff, item_q.word_value, item_q.byte_count);
      end
      WR_STORE: begin
        wr_addr = op_addr;
        wdata   = gp_q;
      end
      default: begin
        wr_addr = op_addr;
        wdata   = gp_q;
      end
    endcase
  end

  cmie_ram #(
    .WIDTH(32),
    .DEPTH(MEM_WORDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mem_wr),
    .waddr_i(wr_addr[IW-1:0]),
    .wdata_i(wdata),
    .re_i   (cmd_i.mem_rd),
    .raddr_i(rd_addr[IW-1:0]),
    .rdata_o(rdata)
  );

  // machine state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q    <= SPACES;
      ic_q    <= '0;
      tog_q   <= 1'b0;
      fp_q    <= '0;
      fl_q    <= '0;
      valid_q <= '0;
    end else if (cmd_i.clear) begin
      gp_q    <= SPACES;
      ic_q    <= '0;
      tog_q   <= 1'b0;
      fp_q    <= '0;
      fl_q    <= '0;
      valid_q <= '0;
    end else begin
      if (cmd_i.mem_wr) begin
        valid_q[wr_addr[IW-1:0]] <= 1'b1;
      end
      if (cmd_i.gp_load) begin
        gp_q <= rd_eff;
      end
      if (cmd_i.tog_load) begin
        tog_q <= (gp_q == rd_eff);
      end
      if (cmd_i.ic_branch) begin
        ic_q <= op_addr;
      end else if (cmd_i.ic_adv) begin
        ic_q <= ic_inc;
      end
      if (cmd_i.fill_set) begin
        fp_q <= op_addr;
        fl_q <= lim;
      end else if (cmd_i.fill_inc) begin
        fp_q <= fp_q + 7'd1;
      end
    end
  end

  // item, instruction, print window and read valid registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.ir_load) begin
      ir_q <= rd_eff;
    end
    if (cmd_i.pd_set) begin
      pd_q <= op_addr;
      pl_q <= lim;
    end else if (cmd_i.pd_inc) begin
      pd_q <= pd_q + 7'd1;
    end
    if (cmd_i.mem_rd) begin
      rdv_q <= valid_q[rd_addr[IW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status        <= cmd_i.emit_status;
      out_q.out_word      <= cmd_i.emit_mem ? rd_eff : 32'd0;
      out_q.counter_after <= ic_q;
      out_q.last          <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status towards the controller
  assign sts_o.func       = item_q.func;
  assign sts_o.load_fault = {1'b0, item_q.word_address} >= 8'(MEM_WORDS);
  assign sts_o.card_end   = item_q.card_end;
  assign sts_o.fill_room  = fp_q < fl_q;
  assign sts_o.op         = op;
  assign sts_o.op_ok      = d2_ok && d3_ok && ({1'b0, op_addr} < 8'(MEM_WORDS));
  assign sts_o.toggle     = tog_q;
  assign sts_o.pd_last    = (pd_q + 7'd1) == pl_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

// ===== rtl/cmie_ctrl.sv =====
// controller: sequencing of requests and run mode
module cmie_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cmie_pkg::cmie_sts_t sts_i,
  output cmie_pkg::cmie_cmd_t cmd_o
);
  import cmie_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_LD_WR, S_FILL_WR, S_DATA_END, S_FETCH, S_DECODE,
    S_OPDONE, S_PD_RD, S_PD_EMIT, S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MODE_IDLE, MODE_WAIT, MODE_HALT
  } mode_e;

  state_e  state_q, state_d;
  mode_e   mode_q, mode_d;
  status_e status_q, status_d;

  assign in_stall_o = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    cmd_o       = '0;
    cmd_o.rd_sel      = RD_IC;
    cmd_o.wr_sel      = WR_STORE;
    cmd_o.emit_status = ST_DONE;
    state_d  = state_q;
    mode_d   = mode_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d  = S_EMIT;
        status_d = ST_IGNORED;
        case (sts_i.func)
          FUNC_CLEAR: begin
            cmd_o.clear = 1'b1;
            mode_d   = MODE_IDLE;
            status_d = ST_DONE;
          end
          FUNC_LOAD: begin
            if (mode_q != MODE_WAIT) begin
              if (sts_i.load_fault) begin
                status_d = ST_FAULT;
              end else begin
                cmd_o.mem_rd = 1'b1;
                cmd_o.rd_sel = RD_WADDR;
                state_d = S_LD_WR;
              end
            end
          end
          FUNC_EXEC: begin
            if (mode_q == MODE_IDLE) begin
              cmd_o.mem_rd = 1'b1;
              cmd_o.rd_sel = RD_IC;
              state_d = S_FETCH;
            end
          end
          FUNC_DATA: begin
            if (mode_q == MODE_WAIT) begin
              if (sts_i.fill_room) begin
                cmd_o.mem_rd = 1'b1;
                cmd_o.rd_sel = RD_FILL;
                state_d = S_FILL_WR;
              end else begin
                state_d = S_DATA_END;
              end
            end
          end
          FUNC_NODATA: begin
            if (mode_q == MODE_WAIT) begin
              mode_d   = MODE_HALT;
              status_d = ST_NODATA;
            end
          end
          default: status_d = ST_IGNORED;
        endcase
      end
      S_LD_WR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.wr_sel = WR_LOAD;
        status_d = ST_DONE;
        state_d  = S_EMIT;
      end
      S_FILL_WR: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.wr_sel   = WR_FILL;
        cmd_o.fill_inc = 1'b1;
        state_d = S_DATA_END;
      end
      S_DATA_END: begin
        if (sts_i.card_end) begin
          mode_d = MODE_IDLE;
          cmd_o.ic_adv = 1'b1;
          status_d = ST_DONE;
        end else begin
          status_d = ST_AWAIT;
        end
        state_d = S_EMIT;
      end
      S_FETCH: begin
        cmd_o.ir_load = 1'b1;
        state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d  = S_EMIT;
        status_d = ST_DONE;
        if (!sts_i.op_ok && sts_i.op != OP_H && sts_i.op != OP_NONE) begin
          status_d = ST_FAULT;
        end else begin
          case (sts_i.op)
            OP_GD: begin
              cmd_o.fill_set = 1'b1;
              mode_d   = MODE_WAIT;
              status_d = ST_AWAIT;
            end
            OP_PD: begin
              cmd_o.pd_set = 1'b1;
              cmd_o.ic_adv = 1'b1;
              state_d = S_PD_RD;
            end
            OP_H: begin
              mode_d   = MODE_HALT;
              status_d = ST_HALTED;
            end
            OP_LR, OP_CR: begin
              cmd_o.mem_rd = 1'b1;
              cmd_o.rd_sel = RD_OPADDR;
              state_d = S_OPDONE;
            end
            OP_SR: begin
              cmd_o.mem_wr = 1'b1;
              cmd_o.wr_sel = WR_STORE;
              cmd_o.ic_adv = 1'b1;
            end
            OP_BT: begin
              cmd_o.ic_branch = sts_i.toggle;
              cmd_o.ic_adv    = !sts_i.toggle;
            end
            default: cmd_o.ic_adv = 1'b1;
          endcase
        end
      end
      S_OPDONE: begin
        cmd_o.gp_load  = (sts_i.op == OP_LR);
        cmd_o.tog_load = (sts_i.op != OP_LR);
        cmd_o.ic_adv   = 1'b1;
        status_d = ST_DONE;
        state_d  = S_EMIT;
      end
      S_PD_RD: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.rd_sel = RD_PD;
        state_d = S_PD_EMIT;
      end
      S_PD_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_PRINT;
          cmd_o.emit_mem    = 1'b1;
          cmd_o.emit_last   = sts_i.pd_last;
          if (sts_i.pd_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.pd_inc = 1'b1;
            state_d = S_PD_RD;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = status_q;
          cmd_o.emit_last   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state, run mode and pending status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= MODE_IDLE;
      status_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      status_q <= status_d;
    end
  end

endmodule

// ===== rtl/card_machine_instruction_executor.sv =====
// top level of the card machine instruction executor
//
// Input channel: in_valid_i / in_stall_o carry one request (func, word
// address, word value, byte count, card end); a request is taken on a
// rising edge with valid high and stall low. Output channel: out_valid_o /
// out_stall_i carry result words (status, printed word, counter, last).
// One request is worked on at a time; in_stall_o is low only while the
// controller is idle. A request giving one result reaches the output
// register after its controller states (execute of LR or CR is longest:
// dispatch, fetch read, decode, operand read, emit). A PD instruction
// prints up to CARD_WORDS words, one store read per printed word.
// The output register lets a new request be taken while the last result
// still waits; a stalled receiver holds the result and the controller
// waits before writing the next one.
// Reset (and a clear-job request) empties the store to spaces through
// per-word valid bits at once, clears the counter, toggle, register and
// run mode; no clearing pass is needed.
module card_machine_instruction_executor #(
  parameter int unsigned MEM_WORDS  = cmie_pkg::MEM_WORDS_DEF,
  parameter int unsigned CARD_WORDS = cmie_pkg::CARD_WORDS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cmie_pkg::cmie_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cmie_pkg::cmie_out_t out_data_o
);
  import cmie_pkg::*;

  cmie_cmd_t cmd;
  cmie_sts_t sts;

  // sequencing
  cmie_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // store and registers
  cmie_datapath #(
    .MEM_WORDS (MEM_WORDS),
    .CARD_WORDS(CARD_WORDS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
